// ----- src/triangular_flow_routing_unit_macros.svh -----
// Assertion macros for the triangular flow routing unit.
// Used by the top level only; no other dependencies.
`ifndef TRIANGULAR_FLOW_ROUTING_UNIT_MACROS_SVH
`define TRIANGULAR_FLOW_ROUTING_UNIT_MACROS_SVH
// Implication check on clk with synchronous reset disable.
`define TFR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication check.
`define TFR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- src/tfr_pkg.sv -----
// Shared constants and types of the triangular flow routing unit.
// No dependencies.
package tfr_pkg;
  localparam int MaxTaps  = 32;
  localparam int IdxW     = $clog2(MaxTaps);
  localparam int LenW     = $clog2(MaxTaps + 1);
  localparam int DataW    = 32;
  localparam int WtW      = LenW;
  localparam int WsumW    = 2 * LenW;
  localparam int ProdW    = DataW + WtW;
  localparam logic [5:0] BaseLenReset = 6'd3;

  typedef logic [DataW-1:0] data_t;

  // Signals from the sequencer to every slot cell.
  typedef struct packed {
    logic            add_en;   // add share at cell 0, rotate the row
    logic            shift_en; // shift the row down one slot, zero at top
  } cell_ctl_t;
endpackage

// ----- src/tfr_if.sv -----
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing; payload type supplied per instance.
interface tfr_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/tfr_div.sv -----
// Restoring bit-serial divider for share = product / wsum.
// Depends on tfr_pkg.
module tfr_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tfr_pkg::ProdW-1:0]     dividend,
  input  logic [tfr_pkg::WsumW-1:0]     divisor,
  output logic                          done,
  output logic [tfr_pkg::ProdW-1:0]     quotient
);
  localparam int CntW = $clog2(tfr_pkg::ProdW + 1);
  logic [tfr_pkg::ProdW-1:0] q_r, q_nxt;
  logic [tfr_pkg::WsumW:0]   rem_r, rem_nxt;
  logic [tfr_pkg::WsumW-1:0] dvs_r;
  logic [CntW-1:0]           cnt_r;
  logic                      busy_r, done_r;
  logic [tfr_pkg::WsumW:0]   trial;

  always_comb begin
    trial   = {rem_r[tfr_pkg::WsumW-1:0], q_r[tfr_pkg::ProdW-1]};
    q_nxt   = {q_r[tfr_pkg::ProdW-2:0], 1'b0};
    rem_nxt = trial;
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt  = trial - {1'b0, dvs_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(tfr_pkg::ProdW);
        q_r    <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

// ----- src/tfr_cell.sv -----
// One slot of the routing store: holds a value and passes it to its neighbor.
// Depends on tfr_pkg.
module tfr_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  tfr_pkg::cell_ctl_t ctl,
  input  tfr_pkg::data_t     rot_in,   // value entering on rotation
  input  tfr_pkg::data_t     shift_in, // value from the slot above
  output tfr_pkg::data_t     value
);
  tfr_pkg::data_t slot_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (ctl.add_en) begin
      slot_r <= rot_in;
    end else if (ctl.shift_en) begin
      slot_r <= shift_in;
    end
  end
  assign value = slot_r;
endmodule

// ----- src/triangular_flow_routing_unit.sv -----
// Triangular flow routing unit: top level with sequencer, divider and slot row.
// Depends on tfr_pkg, tfr_if, tfr_div, tfr_cell and the macros header.
//
// Usage:
//   in  : one beat carries runoff_in (unsigned 16.16) for one time step.
//   out : one beat per input beat, routed_flow (16.16) and saturated.
//   cfg : cfg_we/cfg_wdata write base_length (0 acts as 1, above 32 as 32);
//         write only while idle. Reset value 3.
// Operation: slots live in a row of 32 cells. For each of the first L slots
// the row rotates by one while the shared bit-serial divider forms
// runoff*w_i/wsum; the share is added to cell 0 with saturation and
// re-enters at the top. The rest of the row is rotated through
// untouched, then one shift pops slot 0 as the result.
// One item at a time: the next beat is taken the cycle after the result
// leaves.
// Reset clears all slots and the sequencer. When the receiver stalls, the
// result is held in the output register and no new beat is taken until it
// leaves.
`include "triangular_flow_routing_unit_macros.svh"
module triangular_flow_routing_unit (
  input  logic                clk,
  input  logic                rst_n,
  tfr_if.sink                 in_ch,
  tfr_if.source               out_ch,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_wdata
);
  localparam int N = tfr_pkg::MaxTaps;
  localparam int LW = tfr_pkg::LenW;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_WAIT, S_ROT, S_POP, S_OUT} st_t;
  st_t st_r;

  logic [5:0]              base_r;
  tfr_pkg::data_t          q_r;
  logic [LW-1:0]           len_r;
  logic [tfr_pkg::WsumW-1:0] wsum_r;
  logic [LW-1:0]           idx_r;  // slots visited so far
  logic                    sat_r;
  tfr_pkg::data_t          flow_r;
  logic                    ovalid_r;
  logic                    div_start_r, div_done;
  logic [tfr_pkg::ProdW-1:0] quot;
  logic [tfr_pkg::WtW-1:0] wt;
  logic [LW-1:0]           len_c;
  logic [tfr_pkg::WsumW-1:0] wsum_c;
  tfr_pkg::cell_ctl_t      ctl;
  tfr_pkg::data_t          vals [N];
  tfr_pkg::data_t          head_new;
  logic [tfr_pkg::DataW:0] sum;

  // effective length and weight sum: L even -> h(h+1) with h=L/2, odd -> (h+1)^2
  always_comb begin
    len_c = (base_r == 6'd0) ? LW'(1) :
            ({1'b0, base_r} > 7'(N)) ? LW'(N) : LW'(base_r);
    if (len_c[0])
      wsum_c = tfr_pkg::WsumW'((len_c >> 1) + 1'b1) * tfr_pkg::WsumW'((len_c >> 1) + 1'b1);
    else
      wsum_c = tfr_pkg::WsumW'(len_c >> 1) * tfr_pkg::WsumW'((len_c >> 1) + 1'b1);
  end

  assign wt = ((idx_r + 1'b1) <= (len_r >> 1)) ? (idx_r + 1'b1) : (len_r - idx_r);

  tfr_div u_div (
    .clk, .rst_n, .start(div_start_r),
    .dividend(q_r * tfr_pkg::ProdW'(wt)), .divisor(wsum_r),
    .done(div_done), .quotient(quot)
  );

  always_comb begin
    sum      = {1'b0, vals[0]} + {1'b0, quot[tfr_pkg::DataW-1:0]};
    head_new = sum[tfr_pkg::DataW] ? '1 : sum[tfr_pkg::DataW-1:0];
    ctl.add_en   = (st_r == S_DIV && div_done) || st_r == S_ROT;
    ctl.shift_en = (st_r == S_POP);
  end

  for (genvar g = 0; g < N; g++) begin : g_row
    tfr_pkg::data_t rin, sin;
    if (g == N - 1) begin : g_top
      assign rin = (st_r == S_DIV) ? head_new : vals[0];
      assign sin = '0;
    end else begin : g_mid
      assign rin = vals[g+1];
      assign sin = vals[g+1];
    end
    tfr_cell u_cell (.clk, .rst_n, .ctl, .rot_in(rin), .shift_in(sin), .value(vals[g]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      base_r      <= tfr_pkg::BaseLenReset;
      ovalid_r    <= 1'b0;
      div_start_r <= 1'b0;
      idx_r       <= '0;
      sat_r       <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (cfg_we) base_r <= cfg_wdata;
      case (st_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            q_r         <= in_ch.data;
            len_r       <= len_c;
            wsum_r      <= wsum_c;
            idx_r       <= '0;
            sat_r       <= 1'b0;
            div_start_r <= 1'b1;
            st_r        <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (sum[tfr_pkg::DataW]) sat_r <= 1'b1;
            idx_r <= idx_r + 1'b1;
            if (idx_r + 1'b1 == len_r) begin
              st_r <= (len_r == LW'(N)) ? S_POP : S_ROT;
            end else begin
              div_start_r <= 1'b1;
            end
          end
        end
        S_ROT: begin
          // advance untouched slots until the row is back in place
          idx_r <= idx_r + 1'b1;
          if (idx_r == LW'(N - 1)) st_r <= S_POP;
        end
        S_POP: begin
          flow_r   <= vals[0];
          ovalid_r <= 1'b1;
          st_r     <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            ovalid_r <= 1'b0;
            st_r     <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready  = (st_r == S_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = {flow_r, sat_r};

  `TFR_ASSERT_IMP(a_one_item, out_ch.valid, !in_ch.ready, "input taken while result pending")
  `TFR_ASSERT_NXT(a_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data),
                  "result dropped under stall")
  `TFR_ASSERT_IMP(a_idx, st_r == S_DIV, idx_r < len_r, "slot index beyond length")
endmodule
